// ===== rtl/core/buddy_block_allocator_top_assert.svh =====
// Assertion macros, clocked on clk, disabled while rst_n is low.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define BBA_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBA_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

    localparam int MAX_ORDER_DEF  = 8;
    localparam int POOL_UNITS_DEF = 1024;

    localparam int SIZE_W  = 9;
    localparam int START_W = 10;
    localparam int ADDR_W  = 10;

    // free bitmap word
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_GIVE,
        ST_SET_RD,
        ST_SET_WR,
        ST_FREE_STEP,
        ST_PLACE_RD,
        ST_PLACE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic clearing;
    } status_t;

    function automatic int level_words(int pool, int lv);
        return ((pool >> lv) + WORD_W - 1) / WORD_W;
    endfunction

    // first word of an order's bitmap; orders are packed from order 0 up
    function automatic int word_base(int pool, int lv);
        int b;
        b = 0;
        for (int i = 0; i < lv; i++)
        begin
            b = b + level_words(pool, i);
        end
        return b;
    endfunction

endpackage

// ===== rtl/core/bba_if.sv =====
interface bba_req_if;
    import bba_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [SIZE_W-1:0]  size;
    logic [START_W-1:0] start_req;

    modport source (output valid, output op, output size, output start_req, input ready);
    modport sink   (input valid, input op, input size, input start_req, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output ok, output address, input ready);
    modport sink   (input valid, input ok, input address, output ready);
endinterface

// ===== rtl/core/bba_mem.sv =====
module bba_mem #(
    parameter int DEPTH = 67,
    parameter int AW    = 7
) (
    input  logic                        clk,
    input  logic                        re,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [bba_pkg::WORD_W-1:0]  wdata,
    output logic [bba_pkg::WORD_W-1:0]  rdata
);
    import bba_pkg::*;

    logic [WORD_W-1:0] store [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bba_ctrl.sv =====
module bba_ctrl #(
    parameter int MAX_ORDER   = bba_pkg::MAX_ORDER_DEF,
    parameter int POOL_UNITS  = bba_pkg::POOL_UNITS_DEF,
    parameter int TOTAL_WORDS = 66,
    parameter int AW          = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp,
    output logic                        mem_re,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_addr,
    output logic [bba_pkg::WORD_W-1:0]  mem_wdata,
    input  logic [bba_pkg::WORD_W-1:0]  mem_rdata,
    output bba_pkg::status_t            status
);
    import bba_pkg::*;

    localparam int PW  = $clog2(POOL_UNITS);
    localparam int IW  = ((PW > START_W) ? PW : START_W) + 2;
    localparam int CW  = ((MAX_ORDER + 1 > SIZE_W) ? MAX_ORDER + 1 : SIZE_W) + 1;
    localparam int LVW = $clog2(MAX_ORDER + 1);
    localparam logic [LVW-1:0] TOP_LV = LVW'(MAX_ORDER);
    localparam logic [BIT_W:0] WORD_N = (BIT_W + 1)'(WORD_W);

    // per-order constants
    logic [AW-1:0] lvl_base  [MAX_ORDER+1];
    logic [IW-1:0] lvl_count [MAX_ORDER+1];

    for (genvar g = 0; g <= MAX_ORDER; g++)
    begin : g_tab
        assign lvl_base[g]  = AW'(word_base(POOL_UNITS, g));
        assign lvl_count[g] = IW'(POOL_UNITS >> g);
    end

    state_t            state_reg, state_next;
    logic [LVW-1:0]    lv_reg, lv_next;
    logic [LVW-1:0]    flv_reg, flv_next;
    logic [IW-1:0]     tgt_reg, tgt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     start_reg, start_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     size_reg, size_next;
    logic              op_reg, op_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    logic [AW-1:0]     cur_base, top_base;
    logic [IW-1:0]     cur_count, top_count, flv_count;
    logic [CW-1:0]     cur_bsz, free_bsz, give_half;
    logic [LVW-1:0]    lv_min, lv_dec;
    logic [BIT_W-1:0]  ffs_pos;
    logic [IW-1:0]     bud, free_idx, found_idx, clr_rem;
    logic [WORD_W-1:0] clr_word;
    logic              word_hit, more_words, scan_last, bud_free, size_fail;
    logic              clr_last, give_end, accept, out_take, out_load;

    assign cur_base  = lvl_base[lv_reg];
    assign cur_count = lvl_count[lv_reg];
    assign top_base  = lvl_base[MAX_ORDER];
    assign top_count = lvl_count[MAX_ORDER];
    assign flv_count = lvl_count[flv_reg];

    assign cur_bsz   = CW'(1) << lv_reg;
    assign free_bsz  = CW'(1) << flv_reg;
    assign lv_dec    = LVW'(lv_reg - 1'b1);
    assign give_half = CW'(1) << lv_dec;
    assign size_fail = size_reg > (CW'(1) << MAX_ORDER);

    always_comb
    begin
        lv_min = TOP_LV;
        for (int g = MAX_ORDER; g >= 0; g--)
        begin
            if ((CW'(1) << g) >= size_reg)
            begin
                lv_min = LVW'(g);
            end
        end
    end

    always_comb
    begin
        ffs_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (mem_rdata[b])
            begin
                ffs_pos = BIT_W'(b);
            end
        end
    end

    assign word_hit   = (tgt_reg < cur_count) && (mem_rdata != '0);
    assign more_words = (tgt_reg + IW'(WORD_W)) < cur_count;
    assign scan_last  = (lv_reg == TOP_LV);
    assign found_idx  = {tgt_reg[IW-1:BIT_W], ffs_pos};
    assign bud        = tgt_reg ^ IW'(1);
    assign bud_free   = (lv_reg != TOP_LV) && (bud < cur_count) && mem_rdata[bud[BIT_W-1:0]];
    assign free_idx   = start_reg >> flv_reg;
    assign give_end   = (rem_reg == '0) || (lv_reg == '0);

    // reset contents: top order free, everything else used
    assign clr_rem  = top_count - (IW'(AW'(clr_reg - top_base)) << BIT_W);
    assign clr_word = (clr_reg < top_base) ? '0 :
                      (clr_rem >= IW'(WORD_W)) ? '1 :
                      ({WORD_W{1'b1}} >> (WORD_N - clr_rem[BIT_W:0]));
    assign clr_last = (clr_reg == AW'(TOTAL_WORDS - 1));

    assign accept   = req.valid && req.ready;
    assign out_take = out_valid_reg && rsp.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign mem_addr = (state_reg == ST_CLEAR) ? clr_reg
                                              : AW'(cur_base + AW'(tgt_reg >> BIT_W));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
                if (req.valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
                if (op_reg == OP_FREE)  state_next = ST_FREE_STEP;
                else if (size_fail)     state_next = ST_DONE;
                else                    state_next = ST_SCAN_RD;
            ST_SCAN_RD:
                state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
                if (word_hit)                      state_next = ST_GIVE;
                else if (more_words || !scan_last) state_next = ST_SCAN_RD;
                else                               state_next = ST_DONE;
            ST_GIVE:
                if (give_end)                    state_next = ST_DONE;
                else if (rem_reg >= give_half)   state_next = ST_SET_RD;
            ST_SET_RD:
                state_next = ST_SET_WR;
            ST_SET_WR:
                state_next = ST_GIVE;
            ST_FREE_STEP:
                if (rem_reg >= free_bsz)
                begin
                    if (free_idx < flv_count) state_next = ST_PLACE_RD;
                end
                else if (flv_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            ST_PLACE_RD:
                state_next = ST_PLACE_WR;
            ST_PLACE_WR:
                if (bud_free) state_next = ST_PLACE_RD;
                else          state_next = ST_FREE_STEP;
            ST_DONE:
                if (out_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        lv_next       = lv_reg;
        flv_next      = flv_reg;
        tgt_next      = tgt_reg;
        idx_next      = idx_reg;
        start_next    = start_reg;
        rem_next      = rem_reg;
        size_next     = size_reg;
        op_next       = op_reg;
        clr_next      = clr_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = mem_rdata;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = clr_word;
                clr_next  = AW'(clr_reg + 1'b1);
            end
            ST_IDLE:
                if (accept)
                begin
                    op_next    = req.op;
                    size_next  = CW'(req.size);
                    start_next = IW'(req.start_req);
                end
            ST_DISPATCH:
            begin
                res_ok_next   = 1'b1;
                res_addr_next = '0;
                if (op_reg == OP_FREE)
                begin
                    flv_next = TOP_LV;
                    rem_next = size_reg;
                end
                else if (size_fail)
                begin
                    res_ok_next = 1'b0;
                end
                else
                begin
                    lv_next  = lv_min;
                    tgt_next = '0;
                end
            end
            ST_SCAN_RD:
                mem_re = 1'b1;
            ST_SCAN_CHK:
                if (word_hit)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = mem_rdata & ~(WORD_W'(1) << ffs_pos);
                    idx_next      = found_idx;
                    res_addr_next = ADDR_W'(found_idx << lv_reg);
                    rem_next      = (size_reg >= cur_bsz) ? '0 : CW'(cur_bsz - size_reg);
                end
                else if (more_words)
                begin
                    tgt_next = IW'(tgt_reg + IW'(WORD_W));
                end
                else if (!scan_last)
                begin
                    lv_next  = LVW'(lv_reg + 1'b1);
                    tgt_next = '0;
                end
                else
                begin
                    // pool exhausted
                    res_ok_next = 1'b0;
                end
            ST_GIVE:
                if (!give_end)
                begin
                    lv_next = lv_dec;
                    if (rem_reg >= give_half)
                    begin
                        idx_next = {idx_reg[IW-2:0], 1'b0};
                        tgt_next = {idx_reg[IW-2:0], 1'b1};
                        rem_next = CW'(rem_reg - give_half);
                    end
                    else
                    begin
                        idx_next = {idx_reg[IW-2:0], 1'b1};
                    end
                end
            ST_SET_RD:
                mem_re = 1'b1;
            ST_SET_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata | (WORD_W'(1) << tgt_reg[BIT_W-1:0]);
            end
            ST_FREE_STEP:
                if (rem_reg >= free_bsz)
                begin
                    rem_next   = CW'(rem_reg - free_bsz);
                    start_next = IW'(start_reg + IW'(free_bsz));
                    if (free_idx < flv_count)
                    begin
                        lv_next  = flv_reg;
                        tgt_next = free_idx;
                    end
                end
                else if (flv_reg != '0)
                begin
                    flv_next = LVW'(flv_reg - 1'b1);
                end
            ST_PLACE_RD:
                mem_re = 1'b1;
            ST_PLACE_WR:
            begin
                mem_we = 1'b1;
                if (bud_free)
                begin
                    // buddy free: both go, parent tried one order up
                    mem_wdata = mem_rdata & ~(WORD_W'(3) << {tgt_reg[BIT_W-1:1], 1'b0});
                    lv_next   = LVW'(lv_reg + 1'b1);
                    tgt_next  = tgt_reg >> 1;
                end
                else
                begin
                    mem_wdata = mem_rdata | (WORD_W'(1) << tgt_reg[BIT_W-1:0]);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_addr_next  = out_addr_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok_reg;
            out_addr_next  = res_addr_reg;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lv_reg       <= lv_next;
        flv_reg      <= flv_next;
        tgt_reg      <= tgt_next;
        idx_reg      <= idx_next;
        start_reg    <= start_next;
        rem_reg      <= rem_next;
        size_reg     <= size_next;
        op_reg       <= op_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        out_ok_reg   <= out_ok_next;
        out_addr_reg <= out_addr_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.address     = out_addr_reg;
    assign status.busy     = (state_reg != ST_IDLE);
    assign status.clearing = (state_reg == ST_CLEAR);

endmodule

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Channel  Dir  Word fields
// req      in   op, size, start_req
// rsp      out  ok, address
//
// Allocate: scans 32-bit bitmap words from the smallest fitting order upward (up to
// all 66 words with 1024 units), walks back down one order per step, sets each half freed.
// Free: steps through pieces and order levels, places each piece and merges free buddies upward.
// Accept, dispatch and result add states per word; every bitmap access uses the single RAM port.
// After reset a clearing pass writes all TOTAL_WORDS (66) bitmap words before req is ready.
// A finished word waits in the rsp register; the next request is taken meanwhile.
`include "buddy_block_allocator_top_assert.svh"

module buddy_block_allocator_top #(
    parameter int MAX_ORDER  = bba_pkg::MAX_ORDER_DEF,
    parameter int POOL_UNITS = bba_pkg::POOL_UNITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp
);
    import bba_pkg::*;

    localparam int TOTAL_WORDS = word_base(POOL_UNITS, MAX_ORDER + 1);
    localparam int DEPTH       = TOTAL_WORDS + 1;
    localparam int AW          = $clog2(DEPTH);

    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    status_t           st;

    bba_ctrl #(
        .MAX_ORDER   (MAX_ORDER),
        .POOL_UNITS  (POOL_UNITS),
        .TOTAL_WORDS (TOTAL_WORDS),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_re    (mem_re),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .status    (st)
    );

    bba_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .re    (mem_re),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    `BBA_NEXT(a_accept_busy, req.valid && req.ready, st.busy && !st.clearing, "accept not followed by work")
    `BBA_HOLDS(a_rmw_pair, mem_we && !st.clearing, $past(mem_re) && ($past(mem_addr) == mem_addr), "write without matching read")
    `BBA_HOLDS(a_wr_range, mem_we, mem_addr < AW'(TOTAL_WORDS), "bitmap write out of range")
    `BBA_HOLDS(a_fail_zero, rsp.valid && !rsp.ok, rsp.address == '0, "failed allocate with address")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import bba_pkg::*;

    localparam int MAXO  = MAX_ORDER_DEF;
    localparam int UNITS = POOL_UNITS_DEF;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } grant_t;

    logic clk;
    logic rst_n;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // one free bit per block of each order
    bit     blk_free [0:MAXO][0:UNITS-1];
    grant_t grant_q[$];
    int     errors;
    int     words_sent;
    int     words_checked;
    int     allocs_granted;
    longint cycles;
    bit     calm;
    bit     ready_calm;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic bit blk_is_free(int lv, int idx);
        if (idx < 0 || idx >= (UNITS >> lv))
        begin
            return 1'b0;
        end
        return blk_free[lv][idx];
    endfunction

    function automatic void blk_set(int lv, int idx, bit v);
        if (idx >= 0 && idx < (UNITS >> lv))
        begin
            blk_free[lv][idx] = v;
        end
    endfunction

    function automatic void pool_reset();
        for (int lv = 0; lv <= MAXO; lv++)
        begin
            for (int i = 0; i < UNITS; i++)
            begin
                blk_free[lv][i] = (lv == MAXO);
            end
        end
    endfunction

    function automatic void coalesce(int lv0, int idx0);
        int lv;
        int idx;
        lv  = lv0;
        idx = idx0;
        while (lv < MAXO && blk_is_free(lv, idx ^ 1))
        begin
            blk_set(lv, idx, 1'b0);
            blk_set(lv, idx ^ 1, 1'b0);
            idx = idx >> 1;
            blk_set(lv + 1, idx, 1'b1);
            lv++;
        end
    endfunction

    function automatic grant_t pool_alloc(int size);
        grant_t g;
        int     rest;
        int     idx;
        g = '0;
        if (size > (1 << MAXO))
        begin
            return g;
        end
        for (int lv = 0; lv <= MAXO; lv++)
        begin
            if ((1 << lv) < size)
            begin
                continue;
            end
            idx = -1;
            for (int i = 0; i < (UNITS >> lv); i++)
            begin
                if (blk_free[lv][i])
                begin
                    idx = i;
                    break;
                end
            end
            if (idx < 0)
            begin
                continue;
            end
            blk_set(lv, idx, 1'b0);
            g.ok      = 1'b1;
            g.address = ADDR_W'(idx << lv);
            rest = (size >= (1 << lv)) ? 0 : (1 << lv) - size;
            for (int l = lv - 1; rest > 0 && l >= 0; l--)
            begin
                if (rest >= (1 << l))
                begin
                    idx = 2 * idx;
                    blk_set(l, idx + 1, 1'b1);
                    rest = rest - (1 << l);
                end
                else
                begin
                    idx = 2 * idx + 1;
                end
            end
            return g;
        end
        return g;
    endfunction

    function automatic void pool_release(int start, int size);
        int idx;
        for (int lv = MAXO; lv >= 0; lv--)
        begin
            while (size >= (1 << lv))
            begin
                idx = start >> lv;
                if (idx < (UNITS >> lv))
                begin
                    blk_set(lv, idx, 1'b1);
                    coalesce(lv, idx);
                end
                size  = size - (1 << lv);
                start = start + (1 << lv);
            end
        end
    endfunction

    task automatic send_word(logic op, int size, int start);
        grant_t g;
        while (!calm && $urandom_range(99) < 25)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.op        <= op;
        req.size      <= SIZE_W'(size);
        req.start_req <= START_W'(start);
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        if (op == OP_ALLOC)
        begin
            g = pool_alloc(size & 9'h1FF);
            if (g.ok)
            begin
                allocs_granted++;
            end
        end
        else
        begin
            g = '{ok: 1'b1, address: '0};
            pool_release(start & 10'h3FF, size & 9'h1FF);
        end
        grant_q.push_back(g);
        words_sent++;
    endtask

    // sink side: random back-pressure, or ready held high while ready_calm is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ready_calm ? 1'b1 : ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        grant_t exp_g;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            words_checked++;
            if (grant_q.size() == 0)
            begin
                $error("unexpected rsp word: ok=%0d address=%0d", rsp.ok, rsp.address);
                errors++;
            end
            else
            begin
                exp_g = grant_q.pop_front();
                if (rsp.ok !== exp_g.ok)
                begin
                    $error("ok: expected %0d, got %0d", exp_g.ok, rsp.ok);
                    errors++;
                end
                if (rsp.address !== exp_g.address)
                begin
                    $error("address: expected %0d, got %0d", exp_g.address, rsp.address);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_word(OP_ALLOC, 0, 0);
        send_word(OP_ALLOC, 1, 1023);
        send_word(OP_ALLOC, 3, 0);
        send_word(OP_ALLOC, 256, 0);
        send_word(OP_ALLOC, 257, 0);
        send_word(OP_ALLOC, 511, 0);
        send_word(OP_FREE, 0, 0);
        send_word(OP_FREE, 1, 0);
        send_word(OP_FREE, 3, 5);
        send_word(OP_FREE, 511, 1023);
        send_word(OP_FREE, 300, 900);
        for (int i = 0; i < 5; i++)
        begin
            send_word(OP_ALLOC, 200, 0);
        end
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_FREE, 511, 0);
        send_word(OP_FREE, 511, 512);
        send_word(OP_FREE, 2, 1022);
        send_word(OP_ALLOC, 128, 682);
        send_word(OP_FREE, 256, 513);
    endtask

    task automatic test_alloc_free_cycles(int n);
        int sz;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 6)
            begin
                sz = ($urandom_range(3) == 0) ? $urandom_range(256) : $urandom_range(16);
                send_word(OP_ALLOC, sz, $urandom_range(1023));
            end
            else if ($urandom_range(9) < 8)
            begin
                sz = 1 << $urandom_range(MAXO);
                send_word(OP_FREE, sz, ($urandom_range(1023) / sz) * sz);
            end
            else
            begin
                send_word(OP_FREE, $urandom_range(511), $urandom_range(1023));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.op        = OP_ALLOC;
        req.size      = '0;
        req.start_req = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        allocs_granted = 0;
        calm = 1'b0;
        ready_calm = 1'b0;
        pool_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_alloc_free_cycles(700);
        calm = 1'b1;
        ready_calm = 1'b1;
        test_alloc_free_cycles(250);
        calm = 1'b0;
        ready_calm = 1'b0;
        test_alloc_free_cycles(580);
        req.valid <= 1'b0;
        while (grant_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        $display("Sent %0d words (%0d allocations granted), checked %0d responses.",
                 words_sent, allocs_granted, words_checked);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/bba_mem.sv
rtl/core/bba_ctrl.sv
rtl/core/buddy_block_allocator_top.sv
verif/testbench.sv
